>>> rtl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types, constants and helper functions of the row scan PWM driver.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  // panel geometry and color format
  localparam int unsigned PANEL_ROWS = 32;
  localparam int unsigned HALF_ROWS  = 16;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned CHAN_W     = 5;
  localparam int unsigned COLOR_W    = 15;
  localparam int unsigned COL_OUT_W  = 6;
  localparam int unsigned X_W        = 8;
  localparam int unsigned Y_W        = 6;

  // pwm counter wraps after this value
  localparam logic [CHAN_W-1:0] PWM_MAX       = 5'd30;
  localparam logic [CHAN_W-1:0] PWM_RESET     = 5'd30;
  localparam logic [ROW_W-1:0]  SCAN_ROW_INIT = 4'd15;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic tick_en;
    logic rd_en;
  } lmrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic rd_last;
    logic scan_done;
  } lmrs_stat_t;

  // bit reversal of the pwm count gives the threshold
  function automatic logic [CHAN_W-1:0] reverse5(input logic [CHAN_W-1:0] v);
    logic [CHAN_W-1:0] r;
    for (int i = 0; i < CHAN_W; i++) begin
      r[i] = v[CHAN_W-1-i];
    end
    return r;
  endfunction

  // channel field of a packed color
  function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] c,
                                                input int unsigned idx);
    return c[idx*CHAN_W +: CHAN_W];
  endfunction

endpackage

>>> rtl/led_matrix_row_scan_pwm.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scan_pwm
// Row scan PWM driver for a 32-row LED panel, two rows shown at once.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass with busy high, writing zero to
// every frame store address (16 * 2^ceil(log2(COLUMNS)) per half, never fewer
// than 32, 1024 at 64 columns). A pixel write request leaves busy low. A
// refresh tick request keeps busy high while the frame store is read once per
// column, upper and lower half in parallel, and while the read register drains.
// Its COLUMNS results come on consecutive cycles, each marked by out_strobe for
// one cycle, the last with out_last set in the same cycle that busy falls; the
// receiver must take every result as it comes.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_pwm
  import lmrs_pkg::*;
#(
  parameter int unsigned COLUMNS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [X_W-1:0]       in_pixel_x,
  input  logic [Y_W-1:0]       in_pixel_y,
  input  logic [COLOR_W-1:0]   in_color,
  output logic                 out_strobe,
  output logic                 out_upper_red,
  output logic                 out_upper_green,
  output logic                 out_upper_blue,
  output logic                 out_lower_red,
  output logic                 out_lower_green,
  output logic                 out_lower_blue,
  output logic [COL_OUT_W-1:0] out_column,
  output logic [ROW_W-1:0]     out_row_address,
  output logic                 out_last
);

  lmrs_cmd_t  cmd;
  lmrs_stat_t stat;

  // sequencing
  lmrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // storage and compare
  lmrs_datapath #(.COLUMNS(COLUMNS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_color        (in_color),
    .out_strobe      (out_strobe),
    .out_upper_red   (out_upper_red),
    .out_upper_green (out_upper_green),
    .out_upper_blue  (out_upper_blue),
    .out_lower_red   (out_lower_red),
    .out_lower_green (out_lower_green),
    .out_lower_blue  (out_lower_blue),
    .out_column      (out_column),
    .out_row_address (out_row_address),
    .out_last        (out_last)
  );

  // results of a scan come back to back
  a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a scan");

  // columns count up by one within a scan
  a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_column == COL_OUT_W'($past(out_column) + 1'b1))
    else $error("column skipped");

  // the last result ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("result after last");

endmodule

>>> rtl/lmrs_ram.sv
// ----------------------------------------------------------------------------
// lmrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lmrs_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lmrs_ctrl.sv
// ----------------------------------------------------------------------------
// lmrs_ctrl
// Controller: clearing pass after reset, request acceptance and scan sequencing.
// ----------------------------------------------------------------------------
module lmrs_ctrl
  import lmrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_command,
  input  lmrs_stat_t stat,
  output lmrs_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  // request handshake
  assign accept = start & ~busy_r;

  // commands to the datapath
  always_comb begin
    cmd.clr_en  = (state_r == ST_CLEAR);
    cmd.wr_en   = accept & (in_command == CMD_WRITE);
    cmd.tick_en = accept & (in_command == CMD_TICK);
    cmd.rd_en   = (state_r == ST_SCAN);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (cmd.tick_en) state_nxt = ST_SCAN;
      ST_SCAN:  if (stat.rd_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (stat.scan_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // busy tracks the state register
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != ST_IDLE))
    else $error("busy out of step with state");

  // a tick always starts a scan
  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_en |=> state_r == ST_SCAN)
    else $error("tick did not start a scan");

  // no clearing once the clearing pass has ended
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |=> state_r != ST_CLEAR)
    else $error("clearing pass reentered");

endmodule

>>> rtl/lmrs_datapath.sv
// ----------------------------------------------------------------------------
// lmrs_datapath
// Frame store in two halves, row and pwm counters, read pipeline and the
// threshold compare feeding the result registers.
// ----------------------------------------------------------------------------
module lmrs_datapath
  import lmrs_pkg::*;
#(
  parameter int unsigned COLUMNS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lmrs_cmd_t            cmd,
  output lmrs_stat_t           stat,
  input  logic [X_W-1:0]       in_pixel_x,
  input  logic [Y_W-1:0]       in_pixel_y,
  input  logic [COLOR_W-1:0]   in_color,
  output logic                 out_strobe,
  output logic                 out_upper_red,
  output logic                 out_upper_green,
  output logic                 out_upper_blue,
  output logic                 out_lower_red,
  output logic                 out_lower_green,
  output logic                 out_lower_blue,
  output logic [COL_OUT_W-1:0] out_column,
  output logic [ROW_W-1:0]     out_row_address,
  output logic                 out_last
);

  localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned AW    = ROW_W + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  logic [AW-1:0]      clr_addr_r;
  logic [ROW_W-1:0]   scan_row_r, scan_row_nxt;
  logic [CHAN_W-1:0]  pwm_count_r, pwm_count_nxt;
  logic [CHAN_W-1:0]  thr;
  logic [CW-1:0]      rd_col_r;
  logic               s1_valid_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_last_r;
  logic               in_panel;
  logic               wr_upper, wr_lower;
  logic [AW-1:0]      waddr, raddr;
  logic [COLOR_W-1:0] wdata;
  logic [COLOR_W-1:0] upper_q, lower_q;
  logic               out_strobe_r;
  logic [2:0]         upper_bits_r, lower_bits_r;
  logic [CW-1:0]      out_col_r;
  logic               out_last_r;

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // write port: clearing pass or a pixel write on the panel
  assign in_panel = (in_pixel_x < X_W'(COLUMNS)) && (in_pixel_y < Y_W'(PANEL_ROWS));
  assign wr_upper = cmd.clr_en | (cmd.wr_en & in_panel & ~in_pixel_y[ROW_W]);
  assign wr_lower = cmd.clr_en | (cmd.wr_en & in_panel & in_pixel_y[ROW_W]);
  assign waddr    = cmd.clr_en ? clr_addr_r
                               : {in_pixel_y[ROW_W-1:0], in_pixel_x[CW-1:0]};
  assign wdata    = cmd.clr_en ? '0 : in_color;
  assign raddr    = {scan_row_r, rd_col_r};

  // rows 0 to 15
  lmrs_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram_upper (
    .clk   (clk),
    .we    (wr_upper),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (upper_q)
  );

  // rows 16 to 31
  lmrs_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram_lower (
    .clk   (clk),
    .we    (wr_lower),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (lower_q)
  );

  // row and pwm counters advanced by a tick
  always_comb begin
    scan_row_nxt  = scan_row_r + 1'b1;
    pwm_count_nxt = pwm_count_r;
    if (scan_row_nxt == '0) begin
      pwm_count_nxt = (pwm_count_r == PWM_MAX) ? '0 : pwm_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r  <= SCAN_ROW_INIT;
      pwm_count_r <= PWM_RESET;
    end else if (cmd.tick_en) begin
      scan_row_r  <= scan_row_nxt;
      pwm_count_r <= pwm_count_nxt;
    end
  end

  assign thr = reverse5(pwm_count_r);

  // column read counter and read pipeline stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_col_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_en) begin
        rd_col_r <= '0;
      end else if (cmd.rd_en) begin
        rd_col_r <= rd_col_r + 1'b1;
      end
      s1_valid_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r  <= rd_col_r;
    s1_last_r <= (rd_col_r == COL_LAST);
  end

  assign stat.clr_last  = (clr_addr_r == '1);
  assign stat.rd_last   = (rd_col_r == COL_LAST);
  assign stat.scan_done = s1_valid_r & s1_last_r;

  // threshold compare into the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      upper_bits_r[i] <= chan_of(upper_q, i) > thr;
      lower_bits_r[i] <= chan_of(lower_q, i) > thr;
    end
    out_col_r  <= s1_col_r;
    out_last_r <= s1_last_r;
  end

  assign out_strobe      = out_strobe_r;
  assign out_upper_red   = upper_bits_r[0];
  assign out_upper_green = upper_bits_r[1];
  assign out_upper_blue  = upper_bits_r[2];
  assign out_lower_red   = lower_bits_r[0];
  assign out_lower_green = lower_bits_r[1];
  assign out_lower_blue  = lower_bits_r[2];
  assign out_column      = COL_OUT_W'(out_col_r);
  assign out_row_address = scan_row_r;
  assign out_last        = out_last_r;

  // the row does not move while a scan is in flight
  a_row_stable: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> $stable(scan_row_r))
    else $error("row changed during scan");

  // the last column read is followed by its result stage
  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en && stat.rd_last |=> stat.scan_done)
    else $error("last column lost in pipeline");

  // no pixel write lands during the clearing pass
  a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && cmd.wr_en))
    else $error("write during clearing pass");

endmodule
